// ===== sv/mbfp_pkg.sv =====
// Shared constants, types and a helper function of the MSB-first bit-field packer.
package mbfp_pkg;

   // Size of the byte store and the widths that follow from it.
   localparam int BUFFER_BYTES = 64;
   localparam int ADDR_W       = $clog2(BUFFER_BYTES);
   localparam int BYTE_POS_W   = $clog2(BUFFER_BYTES + 1);
   localparam int POS_W        = BYTE_POS_W + 3;
   localparam int STORE_BITS   = BUFFER_BYTES * 8;

   // A field of up to 32 bits at any bit offset touches at most five bytes.
   localparam int WIN_BYTES = 5;
   localparam int WIN_W     = WIN_BYTES * 8;
   localparam int FIELD_W   = 32;
   localparam int MAX_WIDTH = 32;

   // Action codes carried in the request tuser.
   typedef enum logic [2:0] {
      ACT_CLEAR     = 3'd0,
      ACT_PUT       = 3'd1,
      ACT_GET       = 3'd2,
      ACT_REWIND    = 3'd3,
      ACT_READ_BYTE = 3'd4
   } action_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_BYTE,
      ST_RESP
   } state_type;

   // Access request from the sequencer to the byte store.
   typedef struct packed {
      logic              clear;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } store_req_type;

   // Mask of the low width bits of a field; width runs from 0 to 32.
   function automatic logic [FIELD_W-1:0] field_mask(input logic [5:0] width);
      logic [FIELD_W-1:0] ones;
      ones = '1;
      return ones >> (6'(FIELD_W) - width);
   endfunction

endpackage

// ===== sv/msb_first_bit_field_packer_core.sv =====
// Top level of the MSB-first bit-field packer: sequencer, cursors and result register.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------------------------
//   req_     | in        | req_tvalid/req_tready | tuser: action, sign_extend; tdata: fields
//   rsp_     | out       | rsp_tvalid/rsp_tready | tdata: read_value, payload_length, overflow
//
// Put and get work through the N store bytes (1 to 5) that the field touches, one byte at
// a time, each in a single read/write pass of the store. Read byte passes through a byte
// state before the response state; clear, rewind and dropped accesses go straight to it.
// Reset empties the store at once through its valid bits and rewinds both cursors.
// A waiting result does not stop the next transfer from being taken; the sequencer
// only holds in its response state while the result register is still full.
module msb_first_bit_field_packer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // field_width[5:0], field_value[37:6], byte_index[43:38]
   input  logic [3:0]  req_tuser,   // action[2:0], sign_extend[3]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // read_value[31:0], payload_length[38:32], overflow[39]
);

   localparam int POS_W  = mbfp_pkg::POS_W;
   localparam int ADDR_W = mbfp_pkg::ADDR_W;
   localparam int WIN_W  = mbfp_pkg::WIN_W;

   mbfp_pkg::state_type  state_ff, state_in;
   mbfp_pkg::action_type act_ff, act_in;
   logic [POS_W-1:0]     write_pos_ff, write_pos_in;
   logic [POS_W-1:0]     read_pos_ff, read_pos_in;
   logic [5:0]           width_ff, width_in;
   logic [2:0]           off_ff, off_in;
   logic [2:0]           last_ff, last_in;
   logic [2:0]           cnt_ff, cnt_in;
   logic [ADDR_W-1:0]    base_ff, base_in;
   logic                 sext_ff, sext_in;
   logic                 extract_ff, extract_in;
   logic [WIN_W-1:0]     window_ff, window_in;
   logic [31:0]          result_ff, result_in;
   logic                 ovf_ff, ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [39:0]          rsp_data_ff, rsp_data_in;

   // Request fields.
   mbfp_pkg::action_type req_act;
   logic [5:0]           req_width_raw;
   logic [31:0]          req_value;
   logic                 req_sext;
   logic [5:0]           req_index;

   // Decode of the accepted transfer.
   logic                 req_accept;
   logic [5:0]           width_clamp;
   logic [POS_W-1:0]     cur_pos;
   logic [POS_W:0]       end_pos;
   logic                 fits;
   logic [5:0]           off_width;
   logic [WIN_W-1:0]     put_window;
   logic                 index_ok;

   // Per-byte work and result assembly.
   logic [7:0]           lane;
   logic [7:0]           store_rd_data;
   logic [31:0]          got_shifted;
   logic [31:0]          got_mask;
   logic [31:0]          got_value;
   logic [31:0]          rsp_value;
   logic [6:0]           payload_len;
   logic                 rsp_load;

   mbfp_pkg::store_req_type store_req;

   mbfp_store u_store (
      .clock   (clock),
      .reset   (reset),
      .req     (store_req),
      .rd_data (store_rd_data)
   );

   // Unpack the request channel.
   assign req_act       = mbfp_pkg::action_type'(req_tuser[2:0]);
   assign req_sext      = req_tuser[3];
   assign req_width_raw = req_tdata[5:0];
   assign req_value     = req_tdata[37:6];
   assign req_index     = req_tdata[43:38];

   assign req_tready = (state_ff == mbfp_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // Bound check and field alignment for a put or a get at the relevant cursor.
   always_comb begin
      width_clamp = (req_width_raw > 6'(mbfp_pkg::MAX_WIDTH)) ? 6'(mbfp_pkg::MAX_WIDTH)
                                                               : req_width_raw;
      cur_pos    = (req_act == mbfp_pkg::ACT_PUT) ? write_pos_ff : read_pos_ff;
      end_pos    = {1'b0, cur_pos} + (POS_W + 1)'(width_clamp);
      fits       = (32'(end_pos) <= mbfp_pkg::STORE_BITS);
      off_width  = 6'(cur_pos[2:0]) + width_clamp;
      put_window = WIN_W'(req_value & mbfp_pkg::field_mask(width_clamp))
                   << (6'(WIN_W) - off_width);
      index_ok   = (32'(req_index) < mbfp_pkg::BUFFER_BYTES);
   end

   // Pick the window byte that belongs to the store byte now in hand.
   always_comb begin
      lane = 8'd0;
      for (int j = 0; j < mbfp_pkg::WIN_BYTES; j++) begin
         if (cnt_ff == 3'(j)) begin
            lane = window_ff[WIN_W-1-8*j -: 8];
         end
      end
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbfp_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_act)
                  mbfp_pkg::ACT_PUT, mbfp_pkg::ACT_GET: begin
                     state_in = (width_clamp != 6'd0 && fits) ? mbfp_pkg::ST_RUN
                                                              : mbfp_pkg::ST_RESP;
                  end
                  mbfp_pkg::ACT_READ_BYTE: begin
                     state_in = index_ok ? mbfp_pkg::ST_BYTE : mbfp_pkg::ST_RESP;
                  end
                  default: begin
                     state_in = mbfp_pkg::ST_RESP;
                  end
               endcase
            end
         end
         mbfp_pkg::ST_RUN: begin
            if (cnt_ff == last_ff) begin
               state_in = mbfp_pkg::ST_RESP;
            end
         end
         mbfp_pkg::ST_BYTE: begin
            state_in = mbfp_pkg::ST_RESP;
         end
         mbfp_pkg::ST_RESP: begin
            if (rsp_load) begin
               state_in = mbfp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mbfp_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and store control for each state.
   always_comb begin
      act_in       = act_ff;
      write_pos_in = write_pos_ff;
      read_pos_in  = read_pos_ff;
      width_in     = width_ff;
      off_in       = off_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      base_in      = base_ff;
      sext_in      = sext_ff;
      extract_in   = extract_ff;
      window_in    = window_ff;
      result_in    = result_ff;
      ovf_in       = ovf_ff;

      store_req         = '0;
      store_req.wr_addr = base_ff + ADDR_W'(cnt_ff);
      store_req.wr_data = store_rd_data | lane;
      store_req.rd_addr = base_ff + ADDR_W'(cnt_ff) + ADDR_W'(1);

      unique case (state_ff)
         mbfp_pkg::ST_IDLE: begin
            if (req_accept) begin
               act_in     = req_act;
               width_in   = width_clamp;
               off_in     = cur_pos[2:0];
               last_in    = 3'((off_width - 6'd1) >> 3);
               cnt_in     = 3'd0;
               base_in    = ADDR_W'(cur_pos[POS_W-1:3]);
               sext_in    = req_sext;
               extract_in = 1'b0;
               window_in  = (req_act == mbfp_pkg::ACT_PUT) ? put_window : '0;
               result_in  = 32'd0;
               ovf_in     = 1'b0;
               store_req.rd_addr = ADDR_W'(cur_pos[POS_W-1:3]);
               case (req_act)
                  mbfp_pkg::ACT_CLEAR: begin
                     store_req.clear = 1'b1;
                     write_pos_in    = '0;
                     read_pos_in     = '0;
                  end
                  mbfp_pkg::ACT_PUT: begin
                     if (width_clamp != 6'd0) begin
                        if (fits) begin
                           write_pos_in = end_pos[POS_W-1:0];
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end
                  end
                  mbfp_pkg::ACT_GET: begin
                     if (width_clamp != 6'd0) begin
                        if (fits) begin
                           read_pos_in = end_pos[POS_W-1:0];
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end
                  end
                  mbfp_pkg::ACT_REWIND: begin
                     read_pos_in = '0;
                  end
                  mbfp_pkg::ACT_READ_BYTE: begin
                     store_req.rd_addr = ADDR_W'(req_index);
                     ovf_in            = !index_ok;
                  end
                  default: begin
                  end
               endcase
            end
         end
         mbfp_pkg::ST_RUN: begin
            // One store byte per cycle: merge for a put, collect for a get.
            cnt_in = cnt_ff + 3'd1;
            if (act_ff == mbfp_pkg::ACT_PUT) begin
               store_req.wr_en = 1'b1;
            end else begin
               for (int j = 0; j < mbfp_pkg::WIN_BYTES; j++) begin
                  if (cnt_ff == 3'(j)) begin
                     window_in[WIN_W-1-8*j -: 8] = store_rd_data;
                  end
               end
               if (cnt_ff == last_ff) begin
                  extract_in = 1'b1;
               end
            end
         end
         mbfp_pkg::ST_BYTE: begin
            result_in = 32'(store_rd_data);
         end
         mbfp_pkg::ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // Get extraction with optional sign extension, result select and payload length.
   always_comb begin
      got_shifted = 32'(window_ff >> (6'(WIN_W) - 6'(off_ff) - width_ff));
      got_mask    = mbfp_pkg::field_mask(width_ff);
      got_value   = got_shifted & got_mask;
      if (sext_ff && got_shifted[5'(width_ff - 6'd1)]) begin
         got_value = got_value | ~got_mask;
      end
      rsp_value   = extract_ff ? got_value : result_ff;
      payload_len = 7'(write_pos_ff[POS_W-1:3]) + 7'(|write_pos_ff[2:0]);
   end

   // Result register between the sequencer and the response channel.
   always_comb begin
      rsp_load     = (state_ff == mbfp_pkg::ST_RESP) && (!rsp_valid_ff || rsp_tready);
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {ovf_ff, payload_len, rsp_value};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbfp_pkg::ST_IDLE;
         write_pos_ff <= '0;
         read_pos_ff  <= '0;
         cnt_ff       <= '0;
         extract_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         write_pos_ff <= write_pos_in;
         read_pos_ff  <= read_pos_in;
         cnt_ff       <= cnt_in;
         extract_ff   <= extract_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      width_ff    <= width_in;
      off_ff      <= off_in;
      last_ff     <= last_in;
      base_ff     <= base_in;
      sext_ff     <= sext_in;
      window_ff   <= window_in;
      result_ff   <= result_in;
      ovf_ff      <= ovf_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== sv/mbfp_store.sv =====
// Byte store: synchronous memory with per-byte valid bits so that a clear is immediate.
module mbfp_store (
   input  logic                   clock,
   input  logic                   reset,
   input  mbfp_pkg::store_req_type req,
   output logic [7:0]             rd_data
);

   logic [7:0]                        store_mem [mbfp_pkg::BUFFER_BYTES];
   logic [mbfp_pkg::BUFFER_BYTES-1:0] valid_ff;
   logic [mbfp_pkg::BUFFER_BYTES-1:0] valid_in;
   logic [7:0]                        rd_raw_ff;
   logic                              rd_valid_ff;

   // Memory write port.
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         store_mem[req.wr_addr] <= req.wr_data;
      end
   end

   // Registered memory read port.
   always_ff @(posedge clock) begin
      rd_raw_ff <= store_mem[req.rd_addr];
   end

   // A byte is valid once written since the last clear; others read as zero.
   always_comb begin
      valid_in = valid_ff;
      if (req.clear) begin
         valid_in = '0;
      end else if (req.wr_en) begin
         valid_in[req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[req.rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : 8'd0;

endmodule
